[rtl/core/c128_pkg.sv]
// Package for the Code 128 symbol encoder: symbol codes, enums, plan structs
// and the constant table used by the checksum reduction.
// No dependencies.
package c128_pkg;

  localparam int unsigned MOD_CHECK = 103;
  localparam int unsigned PLAN_DEPTH = 8;

  localparam logic [6:0] SYM_TO_C    = 7'd99;
  localparam logic [6:0] SYM_TO_B    = 7'd100;
  localparam logic [6:0] SYM_TO_A    = 7'd101;
  localparam logic [6:0] SYM_START_B = 7'd104;
  localparam logic [6:0] SYM_STOP    = 7'd106;
  localparam logic [6:0] CHAR_ZERO   = 7'd48;
  localparam logic [6:0] CHAR_NINE   = 7'd57;
  localparam logic [6:0] CHAR_SPACE  = 7'd32;
  localparam logic [6:0] CHAR_LOWER  = 7'd96;
  localparam logic [6:0] DIGIT_BASE  = 7'd16;
  localparam logic [6:0] CTRL_BASE   = 7'd64;

  typedef enum logic [1:0] {
    SET_A,
    SET_B,
    SET_C
  } code_set_t;

  typedef enum logic [1:0] {
    CLS_A,
    CLS_B,
    CLS_NEUTRAL
  } char_cls_t;

  typedef enum logic [1:0] {
    SK_START,
    SK_DATA,
    SK_CHECK,
    SK_STOP
  } sym_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [6:0] value;
  } entry_t;

  typedef struct packed {
    entry_t [PLAN_DEPTH-1:0] entry;
    logic [$clog2(PLAN_DEPTH+1)-1:0] count;
  } plan_t;

  typedef struct packed {
    logic       start;
    logic       data;
    logic [6:0] value;
  } chk_cmd_t;

  typedef logic [6:0] mod_tbl_t [128];

  function automatic mod_tbl_t build_hi_mod();
    mod_tbl_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 7'((i * 128) % MOD_CHECK);
    end
    return t;
  endfunction

  localparam mod_tbl_t HI_MOD = build_hi_mod();

endpackage

[rtl/core/c128_if.sv]
// Valid/ready channel interfaces for message characters and symbol values.
// No dependencies.
interface c128_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface c128_sym_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol_value;
  logic       last_symbol;
  modport source (output valid, output symbol_value, output last_symbol, input ready);
  modport sink (input valid, input symbol_value, input last_symbol, output ready);
endinterface

[rtl/core/code128_symbol_encoder.sv]
// Code 128 symbol encoder top level: sequencer, output register and the
// planner and checksum units. Depends on c128_pkg, c128_if, c128_plan, c128_check.
//
// Usage:
//   char_in  (sink)   : one message character per beat, last_char marks the end.
//   sym_out  (source) : Code 128 symbol values, Start B first, then data and
//                       switch symbols, the checksum and Stop with last_symbol.
//   A character is planned in the cycle it is taken; its symbols then leave
//   one per cycle while sym_out accepts them, through the output register and
//   the shared checksum unit; a character produces zero to seven symbols.
//   char_in.ready is high only while no symbols of the previous character
//   remain to be issued; the last symbol may still wait in the output
//   register. After a take the sequencer enters its run state and then
//   registers the first symbol into the output register.
//   When sym_out stalls, the output register holds and the sequencer waits.
//   Reset clears the code set, digit run and checksum state; the next
//   character opens a new message with Start B.
module code128_symbol_encoder
  import c128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  c128_char_if.sink  char_in,
  c128_sym_if.source sym_out
);

  seq_state_t state, state_next;
  plan_t      plan, list;
  logic [$clog2(PLAN_DEPTH)-1:0] idx;
  entry_t     cur;
  logic       take, slot_free, issue, at_end;
  chk_cmd_t   cmd;
  logic [6:0] check_value;
  logic       out_valid;
  logic [6:0] out_value;
  logic       out_last;

  c128_plan u_plan (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_in.char_code),
    .last_char (char_in.last_char),
    .plan      (plan)
  );

  c128_check u_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .check_value (check_value)
  );

  assign cur = list.entry[idx];
  assign slot_free = !out_valid || sym_out.ready;
  assign at_end = ($bits(list.count)'(idx) + 1'b1) == list.count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && plan.count != '0) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    char_in.ready = (state == ST_IDLE);
    take = char_in.valid && char_in.ready;
    issue = (state == ST_RUN) && slot_free;
    cmd.start = issue && (cur.kind == SK_START);
    cmd.data = issue && (cur.kind == SK_DATA);
    cmd.value = cur.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (take) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (sym_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      list <= plan;
    end
    if (issue) begin
      out_value <= (cur.kind == SK_CHECK) ? check_value : cur.value;
      out_last <= (cur.kind == SK_STOP);
    end
  end

  assign sym_out.valid = out_valid;
  assign sym_out.symbol_value = out_value;
  assign sym_out.last_symbol = out_last;

`ifndef ASSERT_OFF
  a_idx_in_list: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> $bits(list.count)'(idx) < list.count)
    else $error("sequencer index past end of list");
  a_stop_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_value == SYM_STOP)
    else $error("last symbol is not stop");
  a_issue_shows: assert property (@(posedge clk) disable iff (rst)
    issue |=> out_valid) else $error("issued symbol not presented");
`endif

endmodule

[rtl/core/c128_plan.sv]
// Code set and digit-run tracker: turns one character into a list of symbols.
// Depends on c128_pkg.
module c128_plan
  import c128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [6:0] char_code,
  input  logic       last_char,
  output plan_t      plan
);

  logic            started, started_next;
  code_set_t       code_set, set_next;
  logic [3:0]      held_digits [3];
  logic [3:0]      held_next [3];
  logic [1:0]      held_count, hc_next;
  logic            in_long_run, ilr_next;
  logic [3:0]      pair_digit, pd_next;
  logic            pair_pending, pp_next;
  logic [3:0]      n;
  logic            is_digit;
  logic [3:0]      digit;
  char_cls_t       cls, close_cls;
  logic            close_en;

  always_comb begin
    plan = '0;
    n = '0;
    started_next = started;
    set_next = code_set;
    held_next = held_digits;
    hc_next = held_count;
    ilr_next = in_long_run;
    pd_next = pair_digit;
    pp_next = pair_pending;
    is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    digit = char_code[3:0];
    if (char_code < CHAR_SPACE) begin
      cls = CLS_A;
    end else if (char_code >= CHAR_LOWER) begin
      cls = CLS_B;
    end else begin
      cls = CLS_NEUTRAL;
    end
    close_en = last_char || !is_digit;
    close_cls = is_digit ? CLS_A : cls;

    if (!started) begin
      plan.entry[n[2:0]] = '{kind: SK_START, value: SYM_START_B};
      n = n + 4'd1;
      started_next = 1'b1;
    end

    if (is_digit) begin
      if (in_long_run) begin
        if (pair_pending) begin
          plan.entry[n[2:0]] = '{kind: SK_DATA,
                                 value: 7'(pair_digit) * 7'd10 + 7'(digit)};
          n = n + 4'd1;
          pp_next = 1'b0;
        end else begin
          pd_next = digit;
          pp_next = 1'b1;
        end
      end else if (held_count != 2'd3) begin
        held_next[held_count] = digit;
        hc_next = held_count + 2'd1;
      end else begin
        plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_C};
        n = n + 4'd1;
        plan.entry[n[2:0]] = '{kind: SK_DATA,
                               value: 7'(held_digits[0]) * 7'd10 + 7'(held_digits[1])};
        n = n + 4'd1;
        plan.entry[n[2:0]] = '{kind: SK_DATA,
                               value: 7'(held_digits[2]) * 7'd10 + 7'(digit)};
        n = n + 4'd1;
        hc_next = '0;
        ilr_next = 1'b1;
        set_next = SET_C;
      end
    end

    if (close_en) begin
      if (ilr_next) begin
        if (pp_next) begin
          if (close_cls == CLS_B) begin
            plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_B};
            set_next = SET_B;
          end else begin
            plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_A};
            set_next = SET_A;
          end
          n = n + 4'd1;
          plan.entry[n[2:0]] = '{kind: SK_DATA, value: 7'(pd_next) + DIGIT_BASE};
          n = n + 4'd1;
          pp_next = 1'b0;
        end
        ilr_next = 1'b0;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < hc_next) begin
            plan.entry[n[2:0]] = '{kind: SK_DATA, value: 7'(held_next[k]) + DIGIT_BASE};
            n = n + 4'd1;
          end
        end
        hc_next = '0;
      end
    end

    if (!is_digit) begin
      if (set_next == SET_C) begin
        if (cls == CLS_B) begin
          plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_B};
          set_next = SET_B;
        end else begin
          plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_A};
          set_next = SET_A;
        end
        n = n + 4'd1;
      end else if (cls == CLS_A && set_next != SET_A) begin
        plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_A};
        set_next = SET_A;
        n = n + 4'd1;
      end else if (cls == CLS_B && set_next != SET_B) begin
        plan.entry[n[2:0]] = '{kind: SK_DATA, value: SYM_TO_B};
        set_next = SET_B;
        n = n + 4'd1;
      end
      if (set_next == SET_A && char_code < CHAR_SPACE) begin
        plan.entry[n[2:0]] = '{kind: SK_DATA, value: char_code + CTRL_BASE};
      end else begin
        plan.entry[n[2:0]] = '{kind: SK_DATA, value: char_code - CHAR_SPACE};
      end
      n = n + 4'd1;
    end

    if (last_char) begin
      plan.entry[n[2:0]] = '{kind: SK_CHECK, value: '0};
      n = n + 4'd1;
      plan.entry[n[2:0]] = '{kind: SK_STOP, value: SYM_STOP};
      n = n + 4'd1;
      started_next = 1'b0;
      set_next = SET_B;
      hc_next = '0;
      ilr_next = 1'b0;
      pp_next = 1'b0;
    end

    plan.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      code_set <= SET_B;
      held_count <= '0;
      in_long_run <= 1'b0;
      pair_pending <= 1'b0;
    end else if (take) begin
      started <= started_next;
      code_set <= set_next;
      held_count <= hc_next;
      in_long_run <= ilr_next;
      pair_pending <= pp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_digits <= held_next;
      pair_digit <= pd_next;
    end
  end

endmodule

[rtl/core/c128_check.sv]
// Shared weighted-checksum unit: position counter, one product register and
// a mod-103 accumulator. Depends on c128_pkg.
module c128_check
  import c128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  chk_cmd_t   cmd,
  output logic [6:0] check_value
);

  logic [6:0]  pos, pos_inc;
  logic [6:0]  acc, acc_next;
  logic [13:0] prod;
  logic        prod_valid;
  logic [13:0] sum;
  logic [7:0]  part;

  assign pos_inc = (pos == 7'(MOD_CHECK - 1)) ? 7'd0 : pos + 7'd1;

  always_comb begin
    sum = 14'(acc) + (prod_valid ? prod : 14'd0);
    part = 8'(HI_MOD[sum[13:7]]) + 8'(sum[6:0]);
    if (part >= 8'(2 * MOD_CHECK)) begin
      acc_next = 7'(part - 8'(2 * MOD_CHECK));
    end else if (part >= 8'(MOD_CHECK)) begin
      acc_next = 7'(part - 8'(MOD_CHECK));
    end else begin
      acc_next = part[6:0];
    end
  end

  assign check_value = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      acc <= '0;
      prod_valid <= 1'b0;
    end else if (cmd.start) begin
      pos <= '0;
      acc <= 7'(32'(SYM_START_B) % MOD_CHECK);
      prod_valid <= 1'b0;
    end else begin
      acc <= acc_next;
      prod_valid <= cmd.data;
      if (cmd.data) begin
        pos <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data) begin
      prod <= 14'(cmd.value) * 14'(pos_inc);
    end
  end

`ifndef ASSERT_OFF
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    acc < 7'(MOD_CHECK)) else $error("checksum accumulator out of range");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < 7'(MOD_CHECK)) else $error("position out of range");
  a_prod_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.data && !cmd.start |=> prod_valid) else $error("product lost");
`endif

endmodule
